// ----- rtl/centroid_to_pan_tilt_aim_core_assert.svh -----
// assertion macros shared by the aim core
`ifndef CENTROID_TO_PAN_TILT_AIM_CORE_ASSERT_SVH
`define CENTROID_TO_PAN_TILT_AIM_CORE_ASSERT_SVH

// checked only outside reset
`define CTPTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CTPTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ctpta_pkg.sv -----
package ctpta_pkg;

  localparam int IMG_WIDTH_DEF  = 640;
  localparam int IMG_HEIGHT_DEF = 480;

  localparam int POS_W   = 16;
  localparam int ANGLE_W = 16;
  localparam int VIEW_W  = 15;
  localparam int TERM_W  = 29;
  localparam int SUM_W   = 30;

  // stages inside each axis datapath, then origin add, then clamp/output
  localparam int AX_STAGES  = 5;
  localparam int NUM_STAGES = AX_STAGES + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PAN_ORIGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_VIEW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_VIEW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_LOWER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_UPPER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LOWER  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_UPPER  = 3'd7;

  localparam logic signed [ANGLE_W-1:0] PAN_ORIGIN_RST  = 16'sd0;
  localparam logic signed [ANGLE_W-1:0] TILT_ORIGIN_RST = 16'sd0;
  localparam logic [VIEW_W-1:0]         H_VIEW_RST      = 15'd3840;
  localparam logic [VIEW_W-1:0]         V_VIEW_RST      = 15'd2880;
  localparam logic signed [ANGLE_W-1:0] LOWER_RST       = 16'sd1;
  localparam logic signed [ANGLE_W-1:0] UPPER_RST       = 16'sd0;

  typedef struct packed {
    logic [POS_W-1:0] centroid_column;
    logic [POS_W-1:0] centroid_row;
  } in_word_t;

  typedef struct packed {
    logic                      commanded;
    logic signed [ANGLE_W-1:0] pan_angle;
    logic signed [ANGLE_W-1:0] tilt_angle;
  } out_word_t;

endpackage

// ----- rtl/centroid_to_pan_tilt_aim_core.sv -----
// Centroid to pan/tilt aim core. Takes one centroid word per cycle (1/16 pixel)
// while in_stall is low and returns one angle word per centroid (1/64 degree),
// in order. The pan and tilt offset terms each pass a five-stage
// datapath (offset, field-of-view multiply, reciprocal multiply, back multiply,
// remainder correction) that divides by 16 x image size truncating toward zero;
// an origin add and the limit clamp follow. Throughput is one word per cycle;
// while out_stall holds, empty stages keep filling, and in_stall rises only
// when all seven stages hold words. Registers are written through the cfg port
// (always ready) and must only change while no words are in flight. If either
// axis has lower limit above upper limit, commanded is 0 and both angles are 0.
module centroid_to_pan_tilt_aim_core import ctpta_pkg::*; #(
  parameter int IMAGE_WIDTH  = IMG_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMG_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "centroid_to_pan_tilt_aim_core_assert.svh"

  // configuration registers
  logic signed [ANGLE_W-1:0] pan_origin_r;
  logic signed [ANGLE_W-1:0] tilt_origin_r;
  logic [VIEW_W-1:0]         h_view_r;
  logic [VIEW_W-1:0]         v_view_r;
  logic signed [ANGLE_W-1:0] pan_lower_r;
  logic signed [ANGLE_W-1:0] pan_upper_r;
  logic signed [ANGLE_W-1:0] tilt_lower_r;
  logic signed [ANGLE_W-1:0] tilt_upper_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_origin_r  <= PAN_ORIGIN_RST;
      tilt_origin_r <= TILT_ORIGIN_RST;
      h_view_r      <= H_VIEW_RST;
      v_view_r      <= V_VIEW_RST;
      pan_lower_r   <= LOWER_RST;
      pan_upper_r   <= UPPER_RST;
      tilt_lower_r  <= LOWER_RST;
      tilt_upper_r  <= UPPER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAN_ORIGIN:  pan_origin_r  <= signed'(cfg_data);
        REG_TILT_ORIGIN: tilt_origin_r <= signed'(cfg_data);
        REG_H_VIEW:      h_view_r      <= cfg_data[VIEW_W-1:0];
        REG_V_VIEW:      v_view_r      <= cfg_data[VIEW_W-1:0];
        REG_PAN_LOWER:   pan_lower_r   <= signed'(cfg_data);
        REG_PAN_UPPER:   pan_upper_r   <= signed'(cfg_data);
        REG_TILT_LOWER:  tilt_lower_r  <= signed'(cfg_data);
        REG_TILT_UPPER:  tilt_upper_r  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance; a stage loads when empty or draining
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // offset terms
  logic signed [TERM_W-1:0] pan_term;
  logic signed [TERM_W-1:0] tilt_term;

  ctpta_axis #(
    .SIZE (IMAGE_WIDTH)
  ) u_pan_axis (
    .clk  (clk),
    .en   (en[AX_STAGES-1:0]),
    .pos  (in_word.centroid_column),
    .view (h_view_r),
    .term (pan_term)
  );

  ctpta_axis #(
    .SIZE (IMAGE_HEIGHT)
  ) u_tilt_axis (
    .clk  (clk),
    .en   (en[AX_STAGES-1:0]),
    .pos  (in_word.centroid_row),
    .view (v_view_r),
    .term (tilt_term)
  );

  // origin add; tilt term is subtracted since rows grow downward
  logic signed [SUM_W-1:0] pan_sum_r;
  logic signed [SUM_W-1:0] tilt_sum_r;

  always_ff @(posedge clk) begin
    if (en[AX_STAGES]) begin
      pan_sum_r  <= SUM_W'(pan_origin_r) + SUM_W'(pan_term);
      tilt_sum_r <= SUM_W'(tilt_origin_r) - SUM_W'(tilt_term);
    end
  end

  // clamp and output register
  function automatic logic signed [ANGLE_W-1:0] clamp_angle(
    input logic signed [SUM_W-1:0]   val,
    input logic signed [ANGLE_W-1:0] lo,
    input logic signed [ANGLE_W-1:0] hi
  );
    logic signed [ANGLE_W-1:0] res;
    if (val < SUM_W'(lo)) begin
      res = lo;
    end else if (val > SUM_W'(hi)) begin
      res = hi;
    end else begin
      res = val[ANGLE_W-1:0];
    end
    return res;
  endfunction

  logic      axes_ok;
  out_word_t out_nxt;
  out_word_t out_word_r;

  assign axes_ok = (pan_lower_r <= pan_upper_r) && (tilt_lower_r <= tilt_upper_r);

  always_comb begin
    out_nxt = '0;
    if (axes_ok) begin
      out_nxt.commanded  = 1'b1;
      out_nxt.pan_angle  = clamp_angle(pan_sum_r, pan_lower_r, pan_upper_r);
      out_nxt.tilt_angle = clamp_angle(tilt_sum_r, tilt_lower_r, tilt_upper_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_word = out_word_r;

  `CTPTA_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> vld_r == '0, "pipeline not empty after reset")
  `CTPTA_ASSERT(a_stall_only_full, in_stall |-> (&vld_r), "input stalled with an empty stage")
  `CTPTA_ASSERT(a_idle_zero, (out_valid && !out_word.commanded) |-> (out_word.pan_angle == '0 && out_word.tilt_angle == '0), "uncommanded word has nonzero angle")
  `CTPTA_ASSERT(a_pan_in_limits, (out_valid && out_word.commanded) |-> (out_word.pan_angle >= pan_lower_r && out_word.pan_angle <= pan_upper_r), "pan angle outside limits")
  `CTPTA_ASSERT(a_tilt_in_limits, (out_valid && out_word.commanded) |-> (out_word.tilt_angle >= tilt_lower_r && out_word.tilt_angle <= tilt_upper_r), "tilt angle outside limits")

endmodule

// ----- rtl/ctpta_axis.sv -----
module ctpta_axis import ctpta_pkg::*; #(
  parameter int SIZE = IMG_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic [AX_STAGES-1:0]     en,
  input  logic [POS_W-1:0]         pos,
  input  logic [VIEW_W-1:0]        view,
  output logic signed [TERM_W-1:0] term
);

  localparam int     CENTER  = 8 * SIZE;
  localparam int     DIVISOR = 16 * SIZE;
  // floor(2^31 / divisor): estimate is exact or one low for products below 2^31
  localparam longint RECIP   = (64'sd1 <<< 31) / DIVISOR;

  localparam logic signed [17:0] CENTER_W  = 18'(CENTER);
  localparam logic [15:0]        DIVISOR_W = 16'(DIVISOR);
  localparam logic [27:0]        RECIP_W   = 28'(RECIP);

  // stage 0: offset from centre as sign and magnitude
  logic signed [17:0] diff;
  logic signed [17:0] diff_abs;
  logic [15:0] mag0_r;
  logic        neg0_r;

  assign diff     = signed'({2'b00, pos}) - CENTER_W;
  assign diff_abs = diff[17] ? -diff : diff;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag0_r <= diff_abs[15:0];
      neg0_r <= diff[17];
    end
  end

  // stage 1: scale by field of view
  logic [30:0] prod1_r;
  logic        neg1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod1_r <= mag0_r * view;
      neg1_r  <= neg0_r;
    end
  end

  // stage 2: reciprocal multiply for the quotient estimate
  logic [58:0] scaled;
  logic [27:0] est2_r;
  logic [30:0] prod2_r;
  logic        neg2_r;

  assign scaled = prod1_r * RECIP_W;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      est2_r  <= scaled[58:31];
      prod2_r <= prod1_r;
      neg2_r  <= neg1_r;
    end
  end

  // stage 3: multiply estimate back by the divisor
  logic [43:0] back;
  logic [30:0] back3_r;
  logic [27:0] est3_r;
  logic [30:0] prod3_r;
  logic        neg3_r;

  assign back = est2_r * DIVISOR_W;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      back3_r <= back[30:0];
      est3_r  <= est2_r;
      prod3_r <= prod2_r;
      neg3_r  <= neg2_r;
    end
  end

  // stage 4: remainder correction, then restore sign (truncates toward zero)
  logic [30:0]              rem;
  logic                     bump;
  logic [27:0]              quot;
  logic signed [TERM_W-1:0] quot_s;
  logic signed [TERM_W-1:0] term4_r;

  assign rem    = prod3_r - back3_r;
  assign bump   = (rem >= 31'(DIVISOR_W));
  assign quot   = est3_r + {27'd0, bump};
  assign quot_s = signed'({1'b0, quot});

  always_ff @(posedge clk) begin
    if (en[4]) begin
      term4_r <= neg3_r ? -quot_s : quot_s;
    end
  end

  assign term = term4_r;

endmodule

// ----- sim/ctpta_aim_checker.sv -----
module ctpta_aim_checker import ctpta_pkg::*; #(
  parameter int IMAGE_WIDTH  = IMG_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMG_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_word,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    words_pending
);

  logic signed [ANGLE_W-1:0] pan_org, tilt_org;
  logic signed [ANGLE_W-1:0] pan_lo, pan_hi, tilt_lo, tilt_hi;
  logic [VIEW_W-1:0]         h_fov, v_fov;

  out_word_t expected_angles[$];
  int        mismatches = 0;

  // offset from image centre scaled by the field of view, truncated toward zero
  function automatic longint centre_term(input logic [POS_W-1:0] pos, input int size,
                                         input logic [VIEW_W-1:0] fov);
    longint diff, span;
    diff = pos;
    span = fov;
    diff = diff - 8 * size;
    return (diff * span) / (16 * size);
  endfunction

  function automatic out_word_t aim_angles(input in_word_t w);
    longint    pan, tilt;
    out_word_t r;
    r = '0;
    if (pan_lo <= pan_hi && tilt_lo <= tilt_hi) begin
      pan  = pan_org + centre_term(w.centroid_column, IMAGE_WIDTH, h_fov);
      // image rows grow downward, so the tilt term is subtracted
      tilt = tilt_org - centre_term(w.centroid_row, IMAGE_HEIGHT, v_fov);
      if (pan < pan_lo) pan = pan_lo;
      else if (pan > pan_hi) pan = pan_hi;
      if (tilt < tilt_lo) tilt = tilt_lo;
      else if (tilt > tilt_hi) tilt = tilt_hi;
      r.commanded  = 1'b1;
      r.pan_angle  = pan[ANGLE_W-1:0];
      r.tilt_angle = tilt[ANGLE_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    out_word_t want;
    if (!rst_n) begin
      pan_org  = PAN_ORIGIN_RST;
      tilt_org = TILT_ORIGIN_RST;
      h_fov    = H_VIEW_RST;
      v_fov    = V_VIEW_RST;
      pan_lo   = LOWER_RST;
      pan_hi   = UPPER_RST;
      tilt_lo  = LOWER_RST;
      tilt_hi  = UPPER_RST;
      expected_angles.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("aim: unexpected word cmd=%0d pan=%0d tilt=%0d", out_word.commanded,
                     $signed(out_word.pan_angle), $signed(out_word.tilt_angle));
        end else begin
          want = expected_angles.pop_front();
          if (out_word.commanded !== want.commanded || out_word.pan_angle !== want.pan_angle ||
              out_word.tilt_angle !== want.tilt_angle) begin
            mismatches++;
            if (mismatches <= 10)
              $display("aim: mismatch exp cmd=%0d pan=%0d tilt=%0d got cmd=%0d pan=%0d tilt=%0d",
                       want.commanded, $signed(want.pan_angle), $signed(want.tilt_angle),
                       out_word.commanded, $signed(out_word.pan_angle),
                       $signed(out_word.tilt_angle));
          end
        end
      end
      if (in_valid && !in_stall)
        expected_angles.push_back(aim_angles(in_word));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PAN_ORIGIN:  pan_org  = cfg_data;
          REG_TILT_ORIGIN: tilt_org = cfg_data;
          REG_H_VIEW:      h_fov    = cfg_data[VIEW_W-1:0];
          REG_V_VIEW:      v_fov    = cfg_data[VIEW_W-1:0];
          REG_PAN_LOWER:   pan_lo   = cfg_data;
          REG_PAN_UPPER:   pan_hi   = cfg_data;
          REG_TILT_LOWER:  tilt_lo  = cfg_data;
          REG_TILT_UPPER:  tilt_hi  = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count    <= mismatches;
    words_pending <= expected_angles.size();
  end

endmodule

// ----- sim/centroid_to_pan_tilt_aim_core_tb.sv -----
module centroid_to_pan_tilt_aim_core_tb;
  import ctpta_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_WORDS = 105;
  localparam int COL_SPAN    = 16 * IMG_WIDTH_DEF;
  localparam int ROW_SPAN    = 16 * IMG_HEIGHT_DEF;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    fail_count;
  int                    words_pending;
  int                    squeeze_req = 0;

  centroid_to_pan_tilt_aim_core #(
    .IMAGE_WIDTH (IMG_WIDTH_DEF),
    .IMAGE_HEIGHT(IMG_HEIGHT_DEF)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ctpta_aim_checker #(
    .IMAGE_WIDTH (IMG_WIDTH_DEF),
    .IMAGE_HEIGHT(IMG_HEIGHT_DEF)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_word_t centroid(input int col, input int row);
    in_word_t w;
    w.centroid_column = col[POS_W-1:0];
    w.centroid_row    = row[POS_W-1:0];
    return w;
  endfunction

  function automatic int idle_len();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) return 0;
    if (n < 85) return $urandom_range(1, 3);
    if (n < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // full-width values, image-range values and values around the centre
  function automatic int rand_pos(input int span);
    int n;
    n = $urandom_range(0, 9);
    if (n < 4) return $urandom_range(0, 65535);
    if (n < 8) return $urandom_range(0, span - 1);
    return span / 2 + int'($urandom_range(0, 64)) - 32;
  endfunction

  function automatic int rand_angle();
    return int'($urandom_range(0, 46080)) - 23040;
  endfunction

  function automatic int rand_word16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic offer(input in_word_t w, input bit dense);
    int g;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    g = dense ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // every word causes one result, so an empty expectation queue means idle
  task automatic write_setting(input int po, input int to, input int hv, input int vv,
                               input int pl, input int pu, input int tl, input int tu);
    in_valid <= 1'b0;
    wait_drained();
    put_reg(REG_PAN_ORIGIN, po);
    put_reg(REG_TILT_ORIGIN, to);
    put_reg(REG_H_VIEW, hv);
    put_reg(REG_V_VIEW, vv);
    put_reg(REG_PAN_LOWER, pl);
    put_reg(REG_PAN_UPPER, pu);
    put_reg(REG_TILT_LOWER, tl);
    put_reg(REG_TILT_UPPER, tu);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int n, done;
    done = 0;
    forever begin
      if (squeeze_req > done) begin
        // long hold-off so the pipeline fills and stalls its input
        done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = $urandom_range(0, 99);
        if (n < 55) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (n < 60) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(30, 60)) @(posedge clk);
        end else if (n < 88) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (n < 98) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(4, 12)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int po, to, hv, vv, pl, pu, tl, tu, a, b;
    bit dense;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // limits out of reset leave both axes unconfigured
    offer(centroid(0, 0), 1'b0);
    offer(centroid(65535, 65535), 1'b0);

    write_setting(0, 0, 3840, 2880, -32768, 32767, -32768, 32767);
    offer(centroid(0, 0), 1'b0);
    offer(centroid(65535, 65535), 1'b0);
    offer(centroid(COL_SPAN / 2, ROW_SPAN / 2), 1'b0);
    // just off centre: truncation toward zero on both signs
    offer(centroid(COL_SPAN / 2 - 1, ROW_SPAN / 2 + 1), 1'b0);
    offer(centroid(COL_SPAN / 2 + 1, ROW_SPAN / 2 - 1), 1'b0);
    offer(centroid(COL_SPAN - 1, ROW_SPAN - 1), 1'b0);

    // widest views and extreme origins, so both clamp directions are hit
    write_setting(-32768, 32767, 32767, 32767, -23040, 23040, -23040, 23040);
    offer(centroid(0, 65535), 1'b0);
    offer(centroid(65535, 0), 1'b0);
    offer(centroid(COL_SPAN / 2, ROW_SPAN / 2), 1'b0);

    // zero views and single-point limits
    write_setting(23040, -23040, 0, 0, 100, 100, -5, -5);
    offer(centroid(0, 65535), 1'b0);
    offer(centroid(65535, 0), 1'b0);

    // pan unconfigured, then tilt unconfigured
    write_setting(0, 0, 3840, 2880, 10, -10, -100, 100);
    offer(centroid(1000, 2000), 1'b0);
    offer(centroid(9000, 100), 1'b0);
    write_setting(0, 0, 3840, 2880, -100, 100, 50, 49);
    offer(centroid(1000, 2000), 1'b0);
    offer(centroid(9000, 100), 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      po = rand_angle();
      to = rand_angle();
      hv = $urandom_range(0, 23040);
      vv = $urandom_range(0, 23040);
      a  = rand_angle();
      b  = rand_angle();
      pl = (a < b) ? a : b;
      pu = (a < b) ? b : a;
      a  = rand_angle();
      b  = rand_angle();
      tl = (a < b) ? a : b;
      tu = (a < b) ? b : a;
      case (ph)
        1: begin
          po = rand_word16();
          to = rand_word16();
          hv = 32767;
          vv = 32767;
          pl = -32768;
          pu = 32767;
          tl = -32768;
          tu = 32767;
        end
        3: begin
          hv = 0;
          vv = 0;
        end
        4: begin
          // full-width values, so axes are often left unconfigured
          po = rand_word16();
          to = rand_word16();
          hv = $urandom_range(0, 32767);
          vv = $urandom_range(0, 32767);
          pl = rand_word16();
          pu = rand_word16();
          tl = rand_word16();
          tu = rand_word16();
        end
        5: begin
          pl = rand_angle();
          pu = pl;
        end
        7: begin
          po = 0;
          to = 0;
          hv = H_VIEW_RST;
          vv = V_VIEW_RST;
        end
        default: ;
      endcase
      write_setting(po, to, hv, vv, pl, pu, tl, tu);
      if (ph == 2 || ph == 5) squeeze_req <= squeeze_req + 1;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        dense = (ph == 2) || (ph == 5) || ((k / 20) % 3 == 2);
        offer(centroid(rand_pos(COL_SPAN), rand_pos(ROW_SPAN)), dense);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (NUM_STAGES + 8) @(posedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
